// ===== rtl/core/tcc_pkg.sv =====
// Package for the text console cursor engine: types, command codes and character constants.
// It has no dependencies. Every other file of the block refers to it by scoped names.
package tcc_pkg;

    // Command codes of a request.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Character codes with a special meaning.
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] PRINT_LOW  = 8'h20;
    localparam logic [7:0] PRINT_HIGH = 8'h7E;

    // Attribute register reset value and its bus address.
    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam int         APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ATTR_ADDR = 3'd0;

    // Fixed port widths.
    localparam int CELL_W       = 16;
    localparam int INDEX_W      = 11;
    localparam int CURSOR_ROW_W = 5;
    localparam int CURSOR_COL_W = 7;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCROLL,
        S_FILL
    } state_t;

    // Result of one request as seen on the output ports.
    typedef struct packed {
        logic                    done;
        logic [CELL_W-1:0]       cell_data;
        logic [CURSOR_ROW_W-1:0] cursor_row;
        logic [CURSOR_COL_W-1:0] cursor_column;
    } result_t;

endpackage

// ===== rtl/core/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: APB registers, sequencer and cell memory.
// Depends on tcc_pkg, tcc_regs, tcc_ctrl and tcc_cell_ram.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------------
//   request   | start, busy                | command, char_byte, cell_index
//   result    | done (one-cycle strobe)    | cell_data, cursor_row, cursor_column
//   config    | psel, penable, pwrite,     | paddr, pwdata, prdata
//             | pready                     |
//
// A request is taken when start is high and busy is low. Printable and control bytes
// that do not scroll, unused commands and out-of-range reads strobe done after the
// execute state, an in-range read after a further read-wait state, since the cell
// memory read data is registered. A clear walks the cell memory one cell a cycle;
// a scroll copies and blanks one cell a cycle. After reset the block is busy while it
// blanks the memory; configuration writes are taken meanwhile.
// The receiver of done cannot stall.
module text_console_cursor_engine #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           command,
    input  logic [7:0]                           char_byte,
    input  logic [tcc_pkg::INDEX_W-1:0]          cell_index,
    output logic                                 done,
    output logic [tcc_pkg::CELL_W-1:0]           cell_data,
    output logic [tcc_pkg::CURSOR_ROW_W-1:0]     cursor_row,
    output logic [tcc_pkg::CURSOR_COL_W-1:0]     cursor_column,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [7:0]                  attribute;
    tcc_pkg::result_t            result;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tcc_pkg::CELL_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tcc_pkg::CELL_W-1:0]  mem_rdata;

    // Configuration register.
    tcc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .attribute (attribute)
    );

    // Request sequencer.
    tcc_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CELL_COUNT    (CELL_COUNT),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .char_byte  (char_byte),
        .cell_index (cell_index),
        .attribute  (attribute),
        .busy       (busy),
        .result     (result),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Screen cell memory.
    tcc_cell_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done          = result.done;
    assign cell_data     = result.cell_data;
    assign cursor_row    = result.cursor_row;
    assign cursor_column = result.cursor_column;

endmodule

// ===== rtl/core/tcc_cell_ram.sv =====
// Screen cell memory: one write port and one read port with registered read data.
// Depends on tcc_pkg for the cell width.
module tcc_cell_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcc_pkg::CELL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcc_pkg::CELL_W-1:0]  rdata
);

    logic [tcc_pkg::CELL_W-1:0] cell_mem [DEPTH];
    logic [tcc_pkg::CELL_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            cell_mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= cell_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/tcc_regs.sv =====
// APB configuration port holding the attribute register.
// Depends on tcc_pkg for the register address and reset value.
module tcc_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [7:0]                        attribute
);

    logic [7:0] attribute_reg;
    logic       hit;

    assign hit = (paddr == tcc_pkg::ATTR_ADDR);

    // The attribute byte is written in the access phase; other addresses are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attribute_reg <= tcc_pkg::ATTR_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            attribute_reg <= pwdata[7:0];
        end
    end

    // Read data for the attribute register, zero elsewhere.
    assign prdata    = hit ? {24'd0, attribute_reg} : 32'd0;
    assign pready    = 1'b1;
    assign attribute = attribute_reg;

endmodule

// ===== rtl/core/tcc_ctrl.sv =====
// Sequencer of the console: cursor registers, request decode, scroll copy and fill sweeps.
// Depends on tcc_pkg; drives the write and read ports of tcc_cell_ram.
module tcc_ctrl #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    parameter int CELL_COUNT    = 2000,
    parameter int ADDR_W        = 11
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [1:0]                       command,
    input  logic [7:0]                       char_byte,
    input  logic [tcc_pkg::INDEX_W-1:0]      cell_index,
    input  logic [7:0]                       attribute,
    output logic                             busy,
    output tcc_pkg::result_t                 result,
    output logic                             mem_we,
    output logic [ADDR_W-1:0]                mem_waddr,
    output logic [tcc_pkg::CELL_W-1:0]       mem_wdata,
    output logic                             mem_re,
    output logic [ADDR_W-1:0]                mem_raddr,
    input  logic [tcc_pkg::CELL_W-1:0]       mem_rdata
);

    localparam int CNT_W = $clog2(CELL_COUNT + 1);
    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam int COL_W = $clog2(SCREEN_WIDTH);

    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL  = COL_W'(SCREEN_WIDTH - 1);
    localparam logic [CNT_W-1:0] LAST_CELL = CNT_W'(CELL_COUNT - 1);
    localparam logic [CNT_W-1:0] END_CELL  = CNT_W'(CELL_COUNT);
    localparam logic [CNT_W-1:0] ROW_START = CNT_W'(SCREEN_WIDTH);

    tcc_pkg::state_t state_reg, state_next;

    logic [ROW_W-1:0]              row_reg, row_next;
    logic [COL_W-1:0]              col_reg, col_next;
    logic [1:0]                    cmd_reg, cmd_next;
    logic [7:0]                    char_reg, char_next;
    logic [tcc_pkg::INDEX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]              rptr_reg, rptr_next;
    logic [CNT_W-1:0]              wptr_reg, wptr_next;
    logic                          pipe_reg, pipe_next;
    logic                          done_reg, done_next;
    logic [tcc_pkg::CELL_W-1:0]    data_reg, data_next;

    logic [ADDR_W-1:0]             cur_addr;
    logic [tcc_pkg::CELL_W-1:0]    blank_cell;
    logic                          idx_in_range;
    logic                          printable;
    logic                          scroll_rd;

    // Linear address of the cursor cell; the cell before it is one less, across rows too.
    assign cur_addr     = ADDR_W'(row_reg * SCREEN_WIDTH) + ADDR_W'(col_reg);
    assign blank_cell   = {attribute, tcc_pkg::BLANK_CHAR};
    assign idx_in_range = (32'(idx_reg) < CELL_COUNT);
    assign printable    = (char_reg >= tcc_pkg::PRINT_LOW) && (char_reg <= tcc_pkg::PRINT_HIGH);
    assign scroll_rd    = (rptr_reg != END_CELL);

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcc_pkg::S_INIT;
            row_reg   <= '0;
            col_reg   <= '0;
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            pipe_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            pipe_reg  <= pipe_next;
            done_reg  <= done_next;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        char_reg <= char_next;
        idx_reg  <= idx_next;
        data_reg <= data_next;
    end

    // Next state, cursor update and memory accesses.
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd_next   = cmd_reg;
        char_next  = char_reg;
        idx_next   = idx_reg;
        rptr_next  = rptr_reg;
        wptr_next  = wptr_reg;
        pipe_next  = 1'b0;
        done_next  = 1'b0;
        data_next  = data_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_addr;
        mem_wdata  = blank_cell;
        mem_re     = 1'b0;
        mem_raddr  = ADDR_W'(idx_reg);

        unique case (state_reg)
            // Clearing pass after reset, always with the reset attribute.
            tcc_pkg::S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = wptr_reg[ADDR_W-1:0];
                mem_wdata = {tcc_pkg::ATTR_RESET, tcc_pkg::BLANK_CHAR};
                if (wptr_reg == LAST_CELL)
                begin
                    wptr_next  = '0;
                    state_next = tcc_pkg::S_IDLE;
                end
                else
                begin
                    wptr_next = wptr_reg + 1'b1;
                end
            end

            tcc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    char_next  = char_byte;
                    idx_next   = cell_index;
                    state_next = tcc_pkg::S_EXEC;
                end
            end

            tcc_pkg::S_EXEC:
            begin
                data_next  = '0;
                done_next  = 1'b1;
                state_next = tcc_pkg::S_IDLE;
                case (cmd_reg)
                    tcc_pkg::CMD_WRITE:
                    begin
                        if (char_reg == tcc_pkg::CHAR_LF)
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                done_next  = 1'b0;
                                state_next = tcc_pkg::S_SCROLL;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        else if (char_reg == tcc_pkg::CHAR_CR)
                        begin
                            col_next = '0;
                        end
                        else if (char_reg == tcc_pkg::CHAR_BS)
                        begin
                            // Step back and blank; nothing at the origin.
                            if (col_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr - 1'b1;
                                col_next  = col_reg - 1'b1;
                            end
                            else if (row_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr - 1'b1;
                                row_next  = row_reg - 1'b1;
                                col_next  = LAST_COL;
                            end
                        end
                        else if (printable)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {attribute, char_reg};
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                if (row_reg == LAST_ROW)
                                begin
                                    done_next  = 1'b0;
                                    state_next = tcc_pkg::S_SCROLL;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                    end

                    tcc_pkg::CMD_READ:
                    begin
                        if (idx_in_range)
                        begin
                            mem_re     = 1'b1;
                            done_next  = 1'b0;
                            state_next = tcc_pkg::S_RDWAIT;
                        end
                    end

                    tcc_pkg::CMD_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        wptr_next  = '0;
                        done_next  = 1'b0;
                        state_next = tcc_pkg::S_FILL;
                    end

                    default:
                    begin
                        data_next = '0;
                    end
                endcase

                // Scroll copy starts reading at the second row.
                if (state_next == tcc_pkg::S_SCROLL)
                begin
                    rptr_next = ROW_START;
                    wptr_next = '0;
                end
            end

            tcc_pkg::S_RDWAIT:
            begin
                data_next  = mem_rdata;
                done_next  = 1'b1;
                state_next = tcc_pkg::S_IDLE;
            end

            // Copy each cell one row up: read ahead, write the previous read back.
            tcc_pkg::S_SCROLL:
            begin
                mem_raddr = rptr_reg[ADDR_W-1:0];
                if (scroll_rd)
                begin
                    mem_re    = 1'b1;
                    rptr_next = rptr_reg + 1'b1;
                    pipe_next = 1'b1;
                end
                else
                begin
                    state_next = tcc_pkg::S_FILL;
                end
                if (pipe_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wptr_reg[ADDR_W-1:0];
                    mem_wdata = mem_rdata;
                    wptr_next = wptr_reg + 1'b1;
                end
            end

            // Blank from the write pointer to the last cell, then report.
            tcc_pkg::S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = wptr_reg[ADDR_W-1:0];
                if (wptr_reg == LAST_CELL)
                begin
                    wptr_next  = '0;
                    done_next  = 1'b1;
                    state_next = tcc_pkg::S_IDLE;
                end
                else
                begin
                    wptr_next = wptr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = tcc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy                 = (state_reg != tcc_pkg::S_IDLE);
    assign result.done          = done_reg;
    assign result.cell_data     = data_reg;
    assign result.cursor_row    = tcc_pkg::CURSOR_ROW_W'(row_reg);
    assign result.cursor_column = tcc_pkg::CURSOR_COL_W'(col_reg);

endmodule

// ===== rtl/core/tcc_checker.sv =====
// Port-level checks of the text console cursor engine, bound to its top level.
// Depends on tcc_pkg for port widths.
module tcc_checker #(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [tcc_pkg::CURSOR_ROW_W-1:0]  cursor_row,
    input logic [tcc_pkg::CURSOR_COL_W-1:0]  cursor_column
);

    // An accepted request makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy afterwards");

    // A result only follows work in progress.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // The strobe of one result lasts a single cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // The cursor does not move while the block stays idle.
    a_cursor_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && $past(!busy)) |-> ($stable(cursor_row) && $stable(cursor_column)))
        else $error("cursor moved while idle");

    // A reported cursor lies on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((32'(cursor_row) < SCREEN_HEIGHT) && (32'(cursor_column) < SCREEN_WIDTH)))
        else $error("cursor reported off the screen");

endmodule

bind text_console_cursor_engine tcc_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .cursor_row    (cursor_row),
    .cursor_column (cursor_column)
);

// ===== tb/tb_text_console_cursor_engine.sv =====
// Self-checking testbench for the text console cursor engine: a table of directed requests,
// then random phases under several attributes and sender idle rates, checked against a predictor.
// Depends on tcc_pkg and text_console_cursor_engine.
module tb_text_console_cursor_engine;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W   = 80;
    localparam int SCREEN_H   = 25;
    localparam int CELL_COUNT = SCREEN_W * SCREEN_H;

    // Command code that the block must ignore, and a bus address with no register behind it.
    localparam logic [1:0]                     CMD_UNUSED = 2'd3;
    localparam logic [tcc_pkg::APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;

    // Sender idle modes of the random phases.
    typedef enum int {
        IDLE_NONE,
        IDLE_HEAVY,
        IDLE_LIGHT
    } idle_mode_t;

    // Cursor and cell data reported for one request.
    typedef struct packed {
        logic [tcc_pkg::CELL_W-1:0]       cell_word;
        logic [tcc_pkg::CURSOR_ROW_W-1:0] row;
        logic [tcc_pkg::CURSOR_COL_W-1:0] column;
    } cursor_report_t;

    // One row of the directed table; pinned rows carry a hand-written report.
    typedef struct packed {
        logic [1:0]                  cmd;
        logic [7:0]                  ch;
        logic [tcc_pkg::INDEX_W-1:0] idx;
        logic [7:0]                  reps;
        logic                        pinned;
        cursor_report_t              want;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 27;

    // Directed requests, all under the reset attribute.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{tcc_pkg::CMD_READ, 8'h00, 11'd0, 8'd1, 1'b1, '{16'h0720, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd1999, 8'd1, 1'b1, '{16'h0720, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd2000, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'hFF, 11'd2047, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_BS, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::PRINT_LOW, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd1}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::PRINT_HIGH, 11'd2047, 8'd1, 1'b1,
          '{16'h0000, 5'd0, 7'd2}},
        '{tcc_pkg::CMD_WRITE, 8'h1F, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd2}},
        '{tcc_pkg::CMD_WRITE, 8'h7F, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd2}},
        '{tcc_pkg::CMD_WRITE, 8'hFF, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd2}},
        '{tcc_pkg::CMD_WRITE, 8'h00, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd2}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd1, 8'd1, 1'b1, '{16'h077E, 5'd0, 7'd2}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_CR, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_LF, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_BS, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd79}},
        '{tcc_pkg::CMD_WRITE, 8'h41, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd79, 8'd1, 1'b1, '{16'h0741, 5'd1, 7'd0}},
        '{CMD_UNUSED, 8'hFF, 11'd2047, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0}},
        '{tcc_pkg::CMD_CLEAR, 8'h00, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd79, 8'd1, 1'b1, '{16'h0720, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_LF, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd0}},
        '{tcc_pkg::CMD_WRITE, 8'h51, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd1, 7'd1}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_LF, 11'd0, 8'd23, 1'b0, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_WRITE, tcc_pkg::CHAR_LF, 11'd0, 8'd1, 1'b1, '{16'h0000, 5'd24, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd0, 8'd1, 1'b1, '{16'h0751, 5'd24, 7'd0}},
        '{tcc_pkg::CMD_WRITE, 8'h5A, 11'd0, 8'd80, 1'b0, '{16'h0000, 5'd0, 7'd0}},
        '{tcc_pkg::CMD_READ, 8'h00, 11'd1920, 8'd1, 1'b1, '{16'h0720, 5'd24, 7'd0}}
    };

    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 160;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic [1:0]                       command = tcc_pkg::CMD_WRITE;
    logic [7:0]                       char_byte = 8'h00;
    logic [tcc_pkg::INDEX_W-1:0]      cell_index = '0;
    logic                             done;
    logic [tcc_pkg::CELL_W-1:0]       cell_data;
    logic [tcc_pkg::CURSOR_ROW_W-1:0] cursor_row;
    logic [tcc_pkg::CURSOR_COL_W-1:0] cursor_column;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [tcc_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    // Predicted screen, cursor and attribute register.
    logic [tcc_pkg::CELL_W-1:0]       screen_image [CELL_COUNT];
    logic [tcc_pkg::CURSOR_ROW_W-1:0] row_now;
    logic [tcc_pkg::CURSOR_COL_W-1:0] col_now;
    logic [7:0]                       attr_now;

    cursor_report_t pending_reports [$];
    int unsigned    accepted_count = 0;
    int unsigned    mismatch_count = 0;
    logic           pin_valid = 1'b0;
    cursor_report_t pin_report = '0;

    text_console_cursor_engine #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .char_byte     (char_byte),
        .cell_index    (cell_index),
        .done          (done),
        .cell_data     (cell_data),
        .cursor_row    (cursor_row),
        .cursor_column (cursor_column),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
        begin
            $display("[%0t] error: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    function automatic logic [tcc_pkg::CELL_W-1:0] blank_cell();
        return {attr_now, tcc_pkg::BLANK_CHAR};
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
        begin
            screen_image[i] = blank_cell();
        end
    endfunction

    // Shift every row up by one and blank the bottom row.
    function automatic void scroll_screen();
        for (int i = 0; i < CELL_COUNT - SCREEN_W; i++)
        begin
            screen_image[i] = screen_image[i + SCREEN_W];
        end
        for (int i = CELL_COUNT - SCREEN_W; i < CELL_COUNT; i++)
        begin
            screen_image[i] = blank_cell();
        end
        row_now = tcc_pkg::CURSOR_ROW_W'(SCREEN_H - 1);
    endfunction

    function automatic void next_line();
        col_now = '0;
        if (int'(row_now) + 1 >= SCREEN_H)
        begin
            scroll_screen();
        end
        else
        begin
            row_now = row_now + 1'b1;
        end
    endfunction

    function automatic int cursor_cell();
        return int'(row_now) * SCREEN_W + int'(col_now);
    endfunction

    // Effect of one written byte on the screen and the cursor.
    function automatic void print_byte(input logic [7:0] ch);
        if (ch == tcc_pkg::CHAR_LF)
        begin
            next_line();
        end
        else if (ch == tcc_pkg::CHAR_CR)
        begin
            col_now = '0;
        end
        else if (ch == tcc_pkg::CHAR_BS)
        begin
            // Backspace wraps to the previous row and does nothing at the origin.
            if (col_now != 0)
            begin
                col_now = col_now - 1'b1;
                screen_image[cursor_cell()] = blank_cell();
            end
            else if (row_now != 0)
            begin
                row_now = row_now - 1'b1;
                col_now = tcc_pkg::CURSOR_COL_W'(SCREEN_W - 1);
                screen_image[cursor_cell()] = blank_cell();
            end
        end
        else if (ch >= tcc_pkg::PRINT_LOW && ch <= tcc_pkg::PRINT_HIGH)
        begin
            screen_image[cursor_cell()] = {attr_now, ch};
            col_now = col_now + 1'b1;
            if (int'(col_now) >= SCREEN_W)
            begin
                next_line();
            end
        end
    endfunction

    // Predicted report of one request; updates the predicted state.
    function automatic cursor_report_t predict_cursor_report(
        input logic [1:0]                  cmd,
        input logic [7:0]                  ch,
        input logic [tcc_pkg::INDEX_W-1:0] idx
    );
        cursor_report_t rep;
        rep = '0;
        if (cmd == tcc_pkg::CMD_WRITE)
        begin
            print_byte(ch);
        end
        else if (cmd == tcc_pkg::CMD_READ)
        begin
            if (int'(idx) < CELL_COUNT)
            begin
                rep.cell_word = screen_image[idx];
            end
        end
        else if (cmd == tcc_pkg::CMD_CLEAR)
        begin
            blank_screen();
            row_now = '0;
            col_now = '0;
        end
        rep.row    = row_now;
        rep.column = col_now;
        return rep;
    endfunction

    // Monitor: checks results, tracks register writes and predicts every accepted request.
    always @(posedge clk)
    begin : monitor
        cursor_report_t want;
        if (!rst_n)
        begin
            attr_now = tcc_pkg::ATTR_RESET;
            blank_screen();
            row_now = '0;
            col_now = '0;
            pending_reports.delete();
        end
        else
        begin
            if (done)
            begin
                if (pending_reports.size() == 0)
                begin
                    report_mismatch($sformatf("result with no request waiting: cell 0x%04h",
                                              cell_data));
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (cell_data !== want.cell_word)
                    begin
                        report_mismatch($sformatf("cell_data 0x%04h, wanted 0x%04h",
                                                  cell_data, want.cell_word));
                    end
                    if (cursor_row !== want.row)
                    begin
                        report_mismatch($sformatf("cursor_row %0d, wanted %0d",
                                                  cursor_row, want.row));
                    end
                    if (cursor_column !== want.column)
                    begin
                        report_mismatch($sformatf("cursor_column %0d, wanted %0d",
                                                  cursor_column, want.column));
                    end
                end
            end
            if (psel && penable && pwrite && pready && paddr == tcc_pkg::ATTR_ADDR)
            begin
                attr_now = pwdata[7:0];
            end
            if (start && !busy)
            begin
                want = predict_cursor_report(command, char_byte, cell_index);
                if (pin_valid)
                begin
                    want = pin_report;
                end
                pending_reports.push_back(want);
                accepted_count++;
            end
        end
    end

    // Drives one request from a falling edge and returns at the falling edge after it is taken.
    task automatic send_request(
        input logic [1:0]                  cmd,
        input logic [7:0]                  ch,
        input logic [tcc_pkg::INDEX_W-1:0] idx
    );
        int unsigned seen;
        seen = accepted_count;
        start      <= 1'b1;
        command    <= cmd;
        char_byte  <= ch;
        cell_index <= idx;
        do
        begin
            @(negedge clk);
        end
        while (accepted_count == seen);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Lets every outstanding request finish, then writes a register and reads back the attribute.
    task automatic write_register(input logic [tcc_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [31:0] data);
        logic [31:0] readback;
        start <= 1'b0;
        while (pending_reports.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= tcc_pkg::ATTR_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        readback = prdata;
        if (readback !== {24'h0, attr_now})
        begin
            report_mismatch($sformatf("attribute read back 0x%08h, wanted 0x%02h",
                                      readback, attr_now));
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int pick_gap(input idle_mode_t mode);
        int chance;
        chance = 0;
        case (mode)
            IDLE_HEAVY: chance = 71;
            IDLE_LIGHT: chance = 29;
            default:    chance = 0;
        endcase
        if (int'($urandom_range(0, 99)) < chance)
        begin
            return int'($urandom_range(1, 5));
        end
        return 0;
    endfunction

    // Random requests: mostly printable text and line control, with reads, clears and noise.
    task automatic run_random_phase(input int count, input idle_mode_t mode);
        int                          pick;
        logic [1:0]                  cmd;
        logic [7:0]                  ch;
        logic [tcc_pkg::INDEX_W-1:0] idx;
        for (int n = 0; n < count; n++)
        begin
            pick = int'($urandom_range(0, 99));
            cmd  = tcc_pkg::CMD_WRITE;
            ch   = 8'($urandom);
            idx  = tcc_pkg::INDEX_W'($urandom_range(0, (1 << tcc_pkg::INDEX_W) - 1));
            if (pick < 55)
            begin
                ch = 8'($urandom_range(tcc_pkg::PRINT_LOW, tcc_pkg::PRINT_HIGH));
            end
            else if (pick < 65)
            begin
                ch = tcc_pkg::CHAR_LF;
            end
            else if (pick < 70)
            begin
                ch = tcc_pkg::CHAR_CR;
            end
            else if (pick < 78)
            begin
                ch = tcc_pkg::CHAR_BS;
            end
            else if (pick < 82)
            begin
                // Any byte at all, mostly ignored ones.
                ch = 8'($urandom);
            end
            else if (pick < 96)
            begin
                cmd = tcc_pkg::CMD_READ;
                if ($urandom_range(0, 9) == 0)
                begin
                    idx = tcc_pkg::INDEX_W'($urandom_range(CELL_COUNT,
                                                           (1 << tcc_pkg::INDEX_W) - 1));
                end
                else
                begin
                    idx = tcc_pkg::INDEX_W'($urandom_range(0, CELL_COUNT - 1));
                end
            end
            else if (pick < 98)
            begin
                cmd = tcc_pkg::CMD_CLEAR;
            end
            else
            begin
                cmd = CMD_UNUSED;
            end
            send_request(cmd, ch, idx);
            idle_sender(pick_gap(mode));
        end
    endtask

    // Stimulus: reset, register setup, directed table, then random phases.
    initial
    begin : stimulus
        logic [7:0] phase_attr;
        idle_mode_t mode;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The block is busy while it blanks the memory after reset.
        while (busy)
        begin
            @(negedge clk);
        end
        write_register(SPARE_ADDR, 32'hFFFF_FFFF);
        write_register(tcc_pkg::ATTR_ADDR, {24'($urandom), tcc_pkg::ATTR_RESET});

        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            for (int k = 0; k < int'(DIRECTED_ROWS[r].reps); k++)
            begin
                pin_valid  = DIRECTED_ROWS[r].pinned;
                pin_report = DIRECTED_ROWS[r].want;
                send_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].ch,
                             DIRECTED_ROWS[r].idx);
                pin_valid = 1'b0;
            end
        end

        // Each phase sets its attribute from an idle block and uses one of three idle modes in turn.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       phase_attr = 8'h00;
                1:       phase_attr = 8'hFF;
                3:       phase_attr = 8'h5A;
                5:       phase_attr = tcc_pkg::ATTR_RESET;
                default: phase_attr = 8'($urandom);
            endcase
            case (p % 3)
                0:       mode = IDLE_NONE;
                1:       mode = IDLE_HEAVY;
                default: mode = IDLE_LIGHT;
            endcase
            write_register(tcc_pkg::ATTR_ADDR, {24'($urandom), phase_attr});
            run_random_phase(PHASE_ITEMS, mode);
        end

        start <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Run limit, far beyond a run in which every request walks the whole cell memory.
    initial
    begin : run_limit
        #150_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tcc_pkg.sv
rtl/core/tcc_cell_ram.sv
rtl/core/tcc_regs.sv
rtl/core/tcc_ctrl.sv
rtl/core/text_console_cursor_engine.sv
rtl/core/tcc_checker.sv
tb/tb_text_console_cursor_engine.sv
